@@ rtl/gfrc_pkg.sv @@
// Shared constants and stage record types for the GNSS fix record compactor.
// Depends on nothing; used by gnss_fix_record_compactor_top.
package gfrc_pkg;

    // Stream word widths: input fields pack to 235 bits, results to 155 bits.
    localparam int InDataWidth  = 240;
    localparam int OutDataWidth = 160;

    // Horizontal accuracy: mm to dm, saturated. Quotient is n * 5243 >> 19 for n < 25600.
    localparam logic [14:0] HorizSatLimit = 15'd25600;
    localparam logic [12:0] HorizRecip    = 13'd5243;
    localparam logic [7:0]  ByteMax       = 8'd255;

    // Speed accuracy: mm/s to cm/s, saturated. Quotient is n * 52429 >> 19 for n < 2560.
    localparam logic [11:0] SpeedAccSatLimit = 12'd2560;
    localparam logic [15:0] SpeedAccRecip    = 16'd52429;

    // Ground speed: mm/s to cm/s, clamped. Quotient is n * 1677722 >> 24 for n < 655360.
    localparam logic [19:0] SpeedSatLimit = 20'd655360;
    localparam logic [20:0] SpeedRecip    = 21'd1677722;
    localparam logic [15:0] SpeedMax      = 16'd65535;

    // Heading: one 1/256 turn is 140625 units of 1e-5 degree. The offset is sixty
    // whole turns (keeps the sum positive) plus the rounding half step of 70312.
    localparam logic [33:0] HeadingOffset = 34'd2160070312;
    localparam logic [17:0] HeadingStep   = 18'd140625;
    // floor(2^43 / 140625), applied to the heading sum shifted right by 11.
    localparam logic [25:0] HeadingRecip  = 26'd62549994;

    // One accepted input record together with its sequence stamp.
    typedef struct packed {
        logic [7:0]  sequence_num;
        logic [2:0]  fix_type;
        logic        fix_ok;
        logic [7:0]  num_sats;
        logic [31:0] horiz_acc_mm;
        logic [31:0] time_of_week_ms;
        logic [30:0] latitude;
        logic [31:0] longitude;
        logic [31:0] ground_speed_mm_s;
        logic [31:0] speed_acc_mm_s;
        logic [31:0] heading_e5_deg;
    } in_item_t;

    // Record after the first compute stage; heading still needs its correction step.
    typedef struct packed {
        logic [7:0]  sequence_res;
        logic [3:0]  fix_byte;
        logic [7:0]  sats_out;
        logic [7:0]  horiz_acc_dm;
        logic [31:0] time_out_ms;
        logic [30:0] latitude_out;
        logic [31:0] longitude_out;
        logic [15:0] ground_speed_cm_s;
        logic [7:0]  speed_acc_cm_s;
        logic [32:0] heading_sum;
        logic [14:0] heading_quot_est;
    } mid_item_t;

endpackage

@@ rtl/gnss_fix_record_compactor_top.sv @@
// An accepted input word passes through the input, compute and result registers to the output.
// Throughput: one record per cycle unless the output stalls; the three register stages
// (input, compute, result) advance independently, so a full result register does not
// stop input while a stage ahead of it is empty.
// Reset (rst_n low, asynchronous): all stages empty, sequence counter back to 0.
// Uses gfrc_pkg for constants and stage record types.
module gnss_fix_record_compactor_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fix_type[2:0], fix_ok[3], num_sats[11:4], horiz_acc_mm[43:12],
    // time_of_week_ms[75:44], latitude[106:76], longitude[138:107],
    // ground_speed_mm_s[170:139], speed_acc_mm_s[202:171], heading_e5_deg[234:203]
    input  logic [gfrc_pkg::InDataWidth-1:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sequence_res[7:0], fix_byte[11:8], sats_out[19:12], horiz_acc_dm[27:20],
    // time_out_ms[59:28], latitude_out[90:60], longitude_out[122:91],
    // ground_speed_cm_s[138:123], speed_acc_cm_s[146:139], heading_byte[154:147]
    output logic [gfrc_pkg::OutDataWidth-1:0] m_axis_tdata
);

    // Stage registers and their next values.
    logic                 in_valid_reg, in_valid_next;
    gfrc_pkg::in_item_t   in_data_reg, in_data_next;
    logic                 mid_valid_reg, mid_valid_next;
    gfrc_pkg::mid_item_t  mid_data_reg, mid_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [gfrc_pkg::OutDataWidth-1:0] out_data_reg, out_data_next;
    logic [7:0]           seq_reg, seq_next;

    // Handshake and advance signals.
    logic                 in_accept;
    logic                 out_adv;
    logic                 mid_adv;
    logic                 in_adv;

    // First compute stage.
    logic                 horiz_sat;
    logic [27:0]          horiz_prod;
    logic                 speed_acc_sat;
    logic [27:0]          speed_acc_prod;
    logic                 speed_sat;
    logic [40:0]          speed_prod;
    logic [33:0]          heading_wide;
    logic [32:0]          heading_sum;
    logic [47:0]          heading_prod;
    gfrc_pkg::mid_item_t  mid_calc;

    // Second compute stage.
    logic [32:0]          heading_back;
    logic [32:0]          heading_rem;
    logic                 heading_inc;
    logic [7:0]           heading_byte;

    // Each stage moves when the one after it is empty or moving.
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign mid_adv       = !mid_valid_reg || out_adv;
    assign in_adv        = !in_valid_reg || mid_adv;
    assign s_axis_tready = in_adv;
    assign in_accept     = s_axis_tvalid && in_adv;

    // Input register: unpack the word and stamp the sequence number.
    always_comb
    begin
        in_valid_next = in_adv ? s_axis_tvalid : in_valid_reg;
        seq_next      = in_accept ? seq_reg + 8'd1 : seq_reg;
        in_data_next  = in_data_reg;
        if (in_accept)
        begin
            in_data_next.sequence_num      = seq_reg;
            in_data_next.fix_type          = s_axis_tdata[2:0];
            in_data_next.fix_ok            = s_axis_tdata[3];
            in_data_next.num_sats          = s_axis_tdata[11:4];
            in_data_next.horiz_acc_mm      = s_axis_tdata[43:12];
            in_data_next.time_of_week_ms   = s_axis_tdata[75:44];
            in_data_next.latitude          = s_axis_tdata[106:76];
            in_data_next.longitude         = s_axis_tdata[138:107];
            in_data_next.ground_speed_mm_s = s_axis_tdata[170:139];
            in_data_next.speed_acc_mm_s    = s_axis_tdata[202:171];
            in_data_next.heading_e5_deg    = s_axis_tdata[234:203];
        end
    end

    // Horizontal accuracy: saturate large values, else multiply by the reciprocal of 100.
    assign horiz_sat  = (in_data_reg.horiz_acc_mm[31:15] != 17'd0) ||
                        (in_data_reg.horiz_acc_mm[14:0] >= gfrc_pkg::HorizSatLimit);
    assign horiz_prod = 28'(in_data_reg.horiz_acc_mm[14:0]) * 28'(gfrc_pkg::HorizRecip);

    // Speed accuracy: the same with the reciprocal of 10.
    assign speed_acc_sat  = (in_data_reg.speed_acc_mm_s[31:12] != 20'd0) ||
                            (in_data_reg.speed_acc_mm_s[11:0] >= gfrc_pkg::SpeedAccSatLimit);
    assign speed_acc_prod = 28'(in_data_reg.speed_acc_mm_s[11:0]) *
                            28'(gfrc_pkg::SpeedAccRecip);

    // Ground speed: negative gives zero, large values clamp, else divide by 10.
    assign speed_sat  = (in_data_reg.ground_speed_mm_s[30:20] != 11'd0) ||
                        (in_data_reg.ground_speed_mm_s[19:0] >= gfrc_pkg::SpeedSatLimit);
    assign speed_prod = 41'(in_data_reg.ground_speed_mm_s[19:0]) * 41'(gfrc_pkg::SpeedRecip);

    // Heading: shift by whole turns plus half a step, then estimate the step count.
    // The estimate is the true quotient or one below it.
    assign heading_wide = {{2{in_data_reg.heading_e5_deg[31]}}, in_data_reg.heading_e5_deg} +
                          gfrc_pkg::HeadingOffset;
    assign heading_sum  = heading_wide[32:0];
    assign heading_prod = 48'(heading_sum[32:11]) * 48'(gfrc_pkg::HeadingRecip);

    // Assemble the first compute stage result.
    always_comb
    begin
        mid_calc.sequence_res  = in_data_reg.sequence_num;
        mid_calc.fix_byte      = {in_data_reg.fix_ok, in_data_reg.fix_type};
        mid_calc.sats_out      = in_data_reg.num_sats;
        mid_calc.horiz_acc_dm  = horiz_sat ? gfrc_pkg::ByteMax : horiz_prod[26:19];
        mid_calc.time_out_ms   = in_data_reg.time_of_week_ms;
        mid_calc.latitude_out  = in_data_reg.latitude;
        mid_calc.longitude_out = in_data_reg.longitude;
        if (in_data_reg.ground_speed_mm_s[31])
        begin
            mid_calc.ground_speed_cm_s = 16'd0;
        end
        else if (speed_sat)
        begin
            mid_calc.ground_speed_cm_s = gfrc_pkg::SpeedMax;
        end
        else
        begin
            mid_calc.ground_speed_cm_s = speed_prod[39:24];
        end
        mid_calc.speed_acc_cm_s   = speed_acc_sat ? gfrc_pkg::ByteMax : speed_acc_prod[26:19];
        mid_calc.heading_sum      = heading_sum;
        mid_calc.heading_quot_est = heading_prod[46:32];
    end

    // Compute register.
    always_comb
    begin
        mid_valid_next = mid_adv ? in_valid_reg : mid_valid_reg;
        mid_data_next  = (mid_adv && in_valid_reg) ? mid_calc : mid_data_reg;
    end

    // Heading correction: bump the estimate when the remainder covers another step.
    assign heading_back = 33'(mid_data_reg.heading_quot_est) * 33'(gfrc_pkg::HeadingStep);
    assign heading_rem  = mid_data_reg.heading_sum - heading_back;
    assign heading_inc  = heading_rem >= 33'(gfrc_pkg::HeadingStep);
    assign heading_byte = mid_data_reg.heading_quot_est[7:0] + {7'd0, heading_inc};

    // Result register.
    always_comb
    begin
        out_valid_next = out_adv ? mid_valid_reg : out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_adv && mid_valid_reg)
        begin
            out_data_next = {5'd0,
                             heading_byte,
                             mid_data_reg.speed_acc_cm_s,
                             mid_data_reg.ground_speed_cm_s,
                             mid_data_reg.longitude_out,
                             mid_data_reg.latitude_out,
                             mid_data_reg.time_out_ms,
                             mid_data_reg.horiz_acc_dm,
                             mid_data_reg.sats_out,
                             mid_data_reg.fix_byte,
                             mid_data_reg.sequence_res};
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= 8'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        mid_data_reg <= mid_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // An empty result register must never hold off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while the result register is empty");

    // With every stage full and the output stalled, no new word may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && mid_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted into a full pipeline");

    // The heading estimate is never more than one step short.
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg |-> (heading_rem < {gfrc_pkg::HeadingStep, 1'b0}))
        else $error("heading quotient estimate out of range");
`endif

endmodule
